@@ sv/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_SIZE_BITS      = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_FIT_MODE      = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [4:0] BLOCKS_RESET = 5'd16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } fpfa_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic emit;
  } fpfa_ctrl_t;

  typedef struct packed {
    logic scan_more;
    logic out_free;
  } fpfa_status_t;

endpackage

@@ sv/fpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: takes an item, steps the partition scan for a request, then hands off result.
// ----------------------------------------------------------------------------
module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tuser,
  output logic         s_tready,
  input  fpfa_status_t status,
  output fpfa_ctrl_t   ctrl
);

  fpfa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.accept = 1'b1;
          state_next  = (s_tuser == CMD_REQ) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          ctrl.issue = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          ctrl.emit  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/fpfa_dpath.sv @@
// ----------------------------------------------------------------------------
// fpfa_dpath
// Partition size memory, taken/loaded bits, scan compare and result register.
// ----------------------------------------------------------------------------
module fpfa_dpath
  import fpfa_pkg::*;
#(
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = DEF_SIZE_BITS
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,
  input  fpfa_ctrl_t             ctrl,
  output fpfa_status_t           status
);

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [SIZE_BITS-1:0]      mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] loaded;
  logic [MAX_PARTITIONS-1:0] taken;

  logic [1:0]            fit_mode;
  logic [4:0]            blocks_in_use;
  logic [CNT_W-1:0]      count;

  logic                  cmd;
  logic [SIZE_BITS-1:0]  want;
  logic [CNT_W-1:0]      ptr;
  logic [IDX_W-1:0]      ptr_idx;

  logic                  rd_vld;
  logic [SIZE_BITS-1:0]  rd_raw;
  logic                  rd_loaded;
  logic                  rd_taken;
  logic [IDX_W-1:0]      rd_idx;
  logic [SIZE_BITS-1:0]  rd_size;

  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  logic [SIZE_BITS-1:0]  best_size;
  logic                  take;

  logic [3:0]            in_part;
  logic [15:0]           in_size;
  logic                  load_ok;
  logic [IDX_W-1:0]      load_idx;
  logic                  granted;
  logic [SIZE_BITS-1:0]  diff;

  assign in_part  = s_tdata[3:0];
  assign in_size  = s_tdata[19:4];
  assign load_ok  = ctrl.accept && (s_tuser == CMD_LOAD) && (int'(in_part) < MAX_PARTITIONS);
  assign load_idx = IDX_W'(in_part);
  assign ptr_idx  = ptr[IDX_W-1:0];

  always_comb begin
    if (int'(blocks_in_use) > MAX_PARTITIONS) begin
      count = CNT_W'(MAX_PARTITIONS);
    end else begin
      count = CNT_W'(blocks_in_use);
    end
  end

  assign status.scan_more = (ptr < count);
  assign status.out_free  = !m_tvalid || m_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= MODE_FIRST;
      blocks_in_use <= BLOCKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIT_MODE:      fit_mode      <= cfg_wdata[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // size memory: one write port (load), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[load_idx] <= SIZE_BITS'(in_size);
    end
    if (ctrl.issue) begin
      rd_raw <= mem[ptr_idx];
    end
  end

  // never-loaded partitions read as size zero
  assign rd_size = rd_loaded ? rd_raw : '0;

  always_comb begin
    take = 1'b0;
    if (rd_vld && !rd_taken && (rd_size >= want)) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_mode == MODE_BEST) begin
        take = (rd_size < best_size);
      end else if (fit_mode == MODE_WORST) begin
        take = (rd_size > best_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd  <= s_tuser;
      want <= SIZE_BITS'(in_size);
    end
    if (ctrl.issue) begin
      rd_loaded <= loaded[ptr_idx];
      rd_taken  <= taken[ptr_idx];
      rd_idx    <= ptr_idx;
    end
    if (take) begin
      best_idx  <= rd_idx;
      best_size <= rd_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= ctrl.issue;
      if (ctrl.accept) begin
        ptr   <= '0;
        found <= 1'b0;
      end else begin
        if (ctrl.issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
    end
  end

  assign granted = (cmd == CMD_REQ) && found;
  assign diff    = best_size - want;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      taken  <= '0;
    end else begin
      if (load_ok) begin
        loaded[load_idx] <= 1'b1;
        taken[load_idx]  <= 1'b0;
      end
      if (ctrl.emit && granted) begin
        taken[best_idx] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      m_tuser <= cmd;
      m_tdata <= '0;
      if (granted) begin
        m_tdata[0]    <= 1'b1;
        m_tdata[4:1]  <= 4'(best_idx);
        m_tdata[20:5] <= 16'(diff);
      end
    end
  end

endmodule

@@ sv/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// A load item goes from acceptance straight to the result register; a request
// item first scans count entries, count = min(blocks_in_use, partitions).
// Results wait for a free output. Items are taken one at a time, a new one only
// once the last result is loaded; the scan reads one size memory entry per cycle.
// Reset (sync): all partitions free and read as size zero, first fit, 16 in use.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed-partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = DEF_SIZE_BITS
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // part_index[3:0], size_value[19:4]
  input  logic                   s_tuser,   // cmd
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // granted[0], block_index[4:1], leftover[20:5]
  output logic                   m_tuser    // result_kind
);

  fpfa_ctrl_t   ctrl;
  fpfa_status_t status;

  fpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  fpfa_dpath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .ctrl      (ctrl),
    .status    (status)
  );

endmodule
